// ===== rtl/core/md5sh_pkg.sv =====
// md5sh_pkg: shared types, constants and round tables of the md5 stream hasher
// used by every module in rtl/core; no dependencies
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_half;
  } out_item_t;

  // one 64-byte block handed from the front end to the compression engine
  typedef struct packed {
    logic [511:0] words;
    logic         final_blk;
  } blk_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] r;
    unique case ({rnd[5:4], rnd[1:0]})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
      4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = i;
      2'd1: g = 4'((i << 2) + i + 4'd1);
      2'd2: g = 4'((i << 1) + i + 4'd5);
      default: g = 4'((i << 3) - i);
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/md5sh_front.sv =====
// md5sh_front: byte packer, bit counter and padding sequencer
// depends on md5sh_pkg; emits complete blocks toward the block queue
module md5sh_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  md5sh_pkg::in_item_t  in_data_i,
  output logic                 blk_valid_o,
  input  logic                 blk_stall_i,
  output md5sh_pkg::blk_t      blk_o
);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PAD2
  } state_e;

  state_e       state_q;
  logic [511:0] buf_q, buf_d;
  logic [63:0]  cnt_q, cnt_d;
  logic         fin_q;
  logic [511:0] out_words_q;
  logic         out_fin_q;
  logic         out_vld_q;

  logic       accept;
  logic       blk_load;
  logic [5:0] pos;
  logic [5:0] pos2;
  logic [63:0] cnt_inc;

  // the output slot must be free (or draining) to take a new beat
  logic slot_free;
  assign slot_free  = !out_vld_q || !blk_stall_i;
  assign in_stall_o = (state_q != ST_FILL) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos     = cnt_q[8:3];
  assign cnt_inc = in_data_i.byte_valid ? 64'(cnt_q + 64'd8) : cnt_q;
  assign pos2    = cnt_inc[8:3];

  // a block beat is loaded on a full block, on end of message, or for the pad block
  assign blk_load = (accept && (in_data_i.end_of_message ||
                                (in_data_i.byte_valid && pos == 6'd63))) ||
                    (state_q == ST_PAD2 && slot_free);

  // buffer after the byte, then with padding applied
  logic [511:0] with_byte;
  logic [511:0] padded;
  always_comb begin
    with_byte = buf_q;
    if (in_data_i.byte_valid) with_byte[{pos, 3'b000} +: 8] = in_data_i.data_byte;
    padded = with_byte;
    for (int p = 0; p < 64; p++) begin
      if (6'(p) == pos2) padded[p*8 +: 8] = md5sh_pkg::PAD_BYTE;
      else if (6'(p) > pos2) padded[p*8 +: 8] = 8'h00;
    end
  end

  logic [511:0] len_blk;
  always_comb begin
    len_blk = padded;
    len_blk[511:448] = cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      out_vld_q   <= 1'b0;
      out_words_q <= '0;
      out_fin_q   <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      if (blk_load) out_vld_q <= 1'b1;
      else if (!blk_stall_i) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_FILL: begin
          if (accept) begin
            if (in_data_i.end_of_message) begin
              if (pos2 >= 6'd56 || (in_data_i.byte_valid && pos == 6'd63)) begin
                // length does not fit: this block first, then a padding block with the length
                out_fin_q <= 1'b0;
                state_q   <= ST_PAD2;
                cnt_q     <= cnt_inc;
                if (in_data_i.byte_valid && pos == 6'd63) begin
                  out_words_q <= with_byte;
                  fin_q       <= 1'b1; // pad byte goes into next block
                end else begin
                  out_words_q <= padded;
                  fin_q       <= 1'b0;
                end
              end else begin
                out_words_q <= len_blk;
                out_fin_q   <= 1'b1;
                cnt_q       <= '0;
              end
            end else if (in_data_i.byte_valid) begin
              cnt_q <= cnt_inc;
              if (pos == 6'd63) begin
                out_words_q <= with_byte;
                out_fin_q   <= 1'b0;
              end
            end
          end
        end
        ST_PAD2: begin
          if (slot_free) begin
            out_words_q <= {cnt_q, 440'd0, fin_q ? md5sh_pkg::PAD_BYTE : 8'h00};
            out_fin_q   <= 1'b1;
            cnt_q       <= '0;
            state_q     <= ST_FILL;
          end
        end
        default: state_q <= ST_FILL;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end
  always_comb begin
    buf_d = buf_q;
    if (accept && in_data_i.byte_valid) buf_d = with_byte;
  end

  assign blk_valid_o     = out_vld_q;
  assign blk_o.words     = out_words_q;
  assign blk_o.final_blk = out_fin_q;

`ifndef ASSERT_OFF
  a_pad2_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAD2 |-> in_stall_o) else $error("input taken during pad block");
  a_blk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_o && blk_stall_i |=> blk_valid_o && $stable(blk_o))
    else $error("block beat changed while stalled");
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_o && blk_o.final_blk && $rose(blk_valid_o) |-> cnt_q == 64'd0)
    else $error("bit count not cleared after final block");
`endif

endmodule

// ===== rtl/core/md5sh_queue.sv =====
// md5sh_queue: two-entry block queue between front end and compression engine
// depends on md5sh_pkg
module md5sh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  md5sh_pkg::blk_t  wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_stall_i,
  output md5sh_pkg::blk_t  rd_data_o
);

  md5sh_pkg::blk_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("queue pointers inconsistent");
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd1) |-> (wp_q == rp_q)) else $error("queue pointers inconsistent");
`endif

endmodule

// ===== rtl/core/md5sh_engine.sv =====
// md5sh_engine: one-round-per-cycle md5 compression and digest output
// depends on md5sh_pkg; consumes blocks from the queue
module md5sh_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 blk_valid_i,
  output logic                 blk_stall_o,
  input  md5sh_pkg::blk_t      blk_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output md5sh_pkg::out_item_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e       state_q;
  logic [5:0]   rnd_q;
  logic [31:0]  a_q, b_q, c_q, d_q;
  logic [31:0]  h_q [4];
  logic [511:0] w_q;
  logic         fin_q;
  logic         half_q;

  logic [31:0] f, sum, rot, m;
  logic [4:0]  s;
  logic [3:0]  g;
  logic        take;

  assign blk_stall_o = (state_q != ST_IDLE);
  assign take = blk_valid_i && (state_q == ST_IDLE);

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    g   = md5sh_pkg::msg_idx(rnd_q);
    s   = md5sh_pkg::rot_amt(rnd_q);
    m   = w_q[{g, 5'b00000} +: 32];
    sum = a_q + f + md5sh_pkg::ROUND_K[rnd_q] + m;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // digest bytes: chain words little-endian, first byte highest
  logic [63:0] half_val;
  logic [31:0] w0, w1;
  always_comb begin
    w0 = half_q ? h_q[2] : h_q[0];
    w1 = half_q ? h_q[3] : h_q[1];
    half_val = {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
                w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
  end

  always_ff @(posedge clk_i) begin
    if (take) w_q <= blk_i.words;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      half_q  <= 1'b0;
      h_q[0] <= md5sh_pkg::IV0; h_q[1] <= md5sh_pkg::IV1;
      h_q[2] <= md5sh_pkg::IV2; h_q[3] <= md5sh_pkg::IV3;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
            fin_q   <= blk_i.final_blk;
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          a_q <= d_q; d_q <= c_q; c_q <= b_q;
          b_q <= b_q + rot;
          rnd_q <= 6'(rnd_q + 6'd1);
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          half_q  <= 1'b0;
          state_q <= fin_q ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            if (half_q) begin
              h_q[0] <= md5sh_pkg::IV0; h_q[1] <= md5sh_pkg::IV1;
              h_q[2] <= md5sh_pkg::IV2; h_q[3] <= md5sh_pkg::IV3;
              state_q <= ST_IDLE;
            end
            half_q <= !half_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o            = (state_q == ST_OUT);
  assign out_data_o.digest_half = half_val;
  assign out_data_o.half_index  = half_q;
  assign out_data_o.last_half   = half_q;

`ifndef ASSERT_OFF
  a_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && rnd_q != 6'd63 |=> state_q == ST_ROUND)
    else $error("round sequence cut short");
  a_out_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !half_q) else $error("digest run did not start at half 0");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest beat changed while stalled");
`endif

endmodule

// ===== rtl/core/md5_stream_hasher_top.sv =====
// md5_stream_hasher_top: streaming md5 hasher, one message byte per beat
// depends on md5sh_pkg, md5sh_front, md5sh_queue, md5sh_engine
//
// Bytes are accepted one per cycle into a 64-byte buffer; each full block goes
// through a two-entry queue to the compression engine, which runs one md5 round
// per cycle and takes each block through load, 64 rounds and the chain add.
// The front end fills the next block while the engine compresses, so over long
// messages the engine bounds the byte rate; the front end stalls while its block
// beat waits on a full queue, and while it issues the second padding block. An
// end-of-message beat yields one or two padded blocks, then two digest beats
// (half 0 then half 1, last_half on the second) after the engine finishes.
module md5_stream_hasher_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  md5sh_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output md5sh_pkg::out_item_t out_data_o
);

  logic            f_valid, f_stall, e_valid, e_stall;
  md5sh_pkg::blk_t f_blk, e_blk;

  md5sh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .blk_valid_o(f_valid), .blk_stall_i(f_stall), .blk_o(f_blk)
  );

  md5sh_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_blk),
    .rd_valid_o(e_valid), .rd_stall_i(e_stall), .rd_data_o(e_blk)
  );

  md5sh_engine u_engine (
    .clk_i, .rst_ni,
    .blk_valid_i(e_valid), .blk_stall_o(e_stall), .blk_i(e_blk),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== verif/md5_stream_hasher_top_tb.sv =====
// md5_stream_hasher_top_tb: self-checking bench for the streaming md5 hasher
// depends on md5sh_pkg and md5_stream_hasher_top; digests are predicted by an in-bench md5
`timescale 1ns / 1ps

module md5_stream_hasher_top_tb;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  md5sh_pkg::in_item_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  md5sh_pkg::out_item_t out_data_o;

  md5_stream_hasher_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0]          hash_h [4];
  logic [31:0]          msg_w [16];
  logic [63:0]          msg_bits;
  md5sh_pkg::out_item_t digest_q [$];
  int                   n_err = 0;
  bit                   stim_done = 1'b0;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic md5_restart();
    hash_h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    foreach (msg_w[i]) msg_w[i] = '0;
    msg_bits = '0;
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl(a + f + MD5_K[i] + msg_w[g], SHIFTS[(i / 16) * 4 + i % 4]);
      a = t;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
  endtask

  task automatic md5_put(input int pos, input logic [7:0] v);
    msg_w[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  // absorb one accepted beat, queueing the digest halves on end of message
  task automatic md5_absorb(input md5sh_pkg::in_item_t it);
    int pos;
    logic [63:0] half;
    md5sh_pkg::out_item_t r;
    if (it.byte_valid) begin
      pos = int'(msg_bits[8:3]);
      md5_put(pos, it.data_byte);
      msg_bits += 64'd8;
      if (pos == 63) md5_compress();
    end
    if (!it.end_of_message) return;
    pos = int'(msg_bits[8:3]);
    md5_put(pos, md5sh_pkg::PAD_BYTE);
    for (int p = pos + 1; p < 64; p++) md5_put(p, 8'h00);
    if (pos >= 56) begin
      md5_compress();
      foreach (msg_w[i]) msg_w[i] = '0;
    end
    msg_w[14] = msg_bits[31:0];
    msg_w[15] = msg_bits[63:32];
    md5_compress();
    for (int h = 0; h < 2; h++) begin
      half = '0;
      for (int k = 0; k < 8; k++)
        half = {half[55:0], hash_h[(h * 8 + k) / 4][((h * 8 + k) % 4) * 8 +: 8]};
      r.digest_half = half;
      r.half_index = h[0];
      r.last_half = (h == 1);
      digest_q.push_back(r);
    end
    md5_restart();
  endtask

  // directed table; empty-message digest is the well known d41d8cd9...
  typedef struct {
    md5sh_pkg::in_item_t it;
    bit                  has_ref;
    logic [63:0]         ref0;
    logic [63:0]         ref1;
  } row_t;

  row_t plan [$];

  function automatic md5sh_pkg::in_item_t mk(input logic [7:0] b, input bit v, input bit e);
    md5sh_pkg::in_item_t x;
    x.data_byte = b; x.byte_valid = v; x.end_of_message = e;
    return x;
  endfunction

  task automatic send(input md5sh_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    md5_absorb(it);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_msg(input int len, input bit split_end);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && !split_end) send(mk(8'($urandom_range(0, 255)), 1'b1, 1'b1));
      else send(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
      if ($urandom_range(0, 15) == 0) send(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end
    if (split_end || len == 0) send(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // result checker
  always @(posedge clk_i) begin
    md5sh_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data_o);
        n_err++;
      end else begin
        want = digest_q.pop_front();
        if (out_data_o.digest_half !== want.digest_half) begin
          $display("%0t: digest_half expected %h actual %h", $time,
                   want.digest_half, out_data_o.digest_half);
          n_err++;
        end
        if (out_data_o.half_index !== want.half_index) begin
          $display("%0t: half_index expected %b actual %b", $time,
                   want.half_index, out_data_o.half_index);
          n_err++;
        end
        if (out_data_o.last_half !== want.last_half) begin
          $display("%0t: last_half expected %b actual %b", $time,
                   want.last_half, out_data_o.last_half);
          n_err++;
        end
      end
    end
  end

  // receiver stalls: mostly short, sometimes long, with free-running stretches
  initial begin
    forever begin
      @(posedge clk_i);
      if (stim_done) out_stall_i <= 1'b0;
      else if ($urandom_range(0, 99) < 30) out_stall_i <= 1'b0;
      else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 3))
          @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20ms;
    $display("md5_stream_hasher_top_tb: errors");
    $finish;
  end

  initial begin
    int sent;
    md5_restart();
    plan.push_back('{mk(8'h00, 1'b0, 1'b1), 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e});
    plan.push_back('{mk(8'h00, 1'b0, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h61, 1'b1, 1'b1), 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661});
    plan.push_back('{mk(8'h00, 1'b1, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'hff, 1'b1, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h80, 1'b1, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h7f, 1'b1, 1'b1), 1'b0, '0, '0});
    plan.push_back('{mk(8'hff, 1'b0, 1'b1), 1'b0, '0, '0});
    plan.push_back('{mk(8'haa, 1'b1, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h55, 1'b0, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h55, 1'b1, 1'b0), 1'b0, '0, '0});
    plan.push_back('{mk(8'h00, 1'b0, 1'b1), 1'b0, '0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send(plan[i].it);
      if (plan[i].has_ref) begin
        // typed-in digests must agree with the predictor too
        if (digest_q[digest_q.size() - 2].digest_half !== plan[i].ref0 ||
            digest_q[digest_q.size() - 1].digest_half !== plan[i].ref1) begin
          $display("%0t: table digest expected %h%h predicted %h%h", $time,
                   plan[i].ref0, plan[i].ref1, digest_q[digest_q.size() - 2].digest_half,
                   digest_q[digest_q.size() - 1].digest_half);
          n_err++;
        end
      end
    end

    // padding boundaries: lengths around 55, 56, 63, 64 and two blocks
    send_msg(55, 1'b0); send_msg(56, 1'b0); send_msg(63, 1'b1);
    in_valid_i <= 1'b0;
    drain();
    send_msg(64, 1'b0); send_msg(120, 1'b1); send_msg(128, 1'b0);

    sent = 0;
    while (sent < 160) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
      send_msg(len, $urandom_range(0, 3) == 0);
      sent += len + 1;
      if ($urandom_range(0, 15) == 0) begin
        in_valid_i <= 1'b0;
        drain();
      end
    end
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    stim_done = 1'b1;
    drain();
    repeat (300) @(posedge clk_i);
    if (n_err == 0 && digest_q.size() == 0) $display("md5_stream_hasher_top_tb: clean");
    else $display("md5_stream_hasher_top_tb: errors");
    $finish;
  end

endmodule
